/* rtl/core/ssm_pkg.sv */
// ----------------------------------------------------------------------------
// ssm_pkg
// Types and constants shared by the sorted set merge front end, back end and
// top level.
// ----------------------------------------------------------------------------
package ssm_pkg;

  localparam int unsigned SET_OP_W    = 3;
  localparam int unsigned ELEM_W      = 32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Operation codes held in the configuration register.
  localparam logic [SET_OP_W-1:0] OP_INTERSECT  = 3'd0;
  localparam logic [SET_OP_W-1:0] OP_UNION      = 3'd1;
  localparam logic [SET_OP_W-1:0] OP_DIFF       = 3'd2;
  localparam logic [SET_OP_W-1:0] OP_HAS_COMMON = 3'd3;
  localparam logic [SET_OP_W-1:0] OP_SUBSET     = 3'd4;
  localparam logic [SET_OP_W-1:0] OP_HAS_DIFF   = 3'd5;

  localparam logic LIST_A = 1'b0;

  typedef struct packed {
    logic              which_list;
    logic [ELEM_W-1:0] element;
    logic              has_element;
    logic              run;
  } in_item_t;

  typedef struct packed {
    logic [ELEM_W-1:0] result_value;
    logic              carries_element;
    logic              answer;
    logic              overflow;
    logic              last;
  } out_item_t;

  // Classified word handed from the front end to the back end.
  typedef struct packed {
    logic              store_a;
    logic              store_b;
    logic              run;
    logic [ELEM_W-1:0] element;
  } load_cmd_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_PRIME,
    BS_MERGE
  } back_state_t;

endpackage

/* rtl/core/ssm_front.sv */
// ----------------------------------------------------------------------------
// ssm_front
// Accepts input words, classifies them into load/run commands and holds them
// in a short queue until the back end takes them.
// ----------------------------------------------------------------------------
module ssm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ssm_pkg::in_item_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output ssm_pkg::load_cmd_t cmd_data
);
  import ssm_pkg::*;

  load_cmd_t           q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   fill_r, fill_nxt;
  load_cmd_t           cmd_in;
  logic                push, pop;

  always_comb begin
    cmd_in.store_a = in_data.has_element && (in_data.which_list == LIST_A);
    cmd_in.store_b = in_data.has_element && (in_data.which_list != LIST_A);
    cmd_in.run     = in_data.run;
    cmd_in.element = in_data.element;
  end

  assign in_ready  = (fill_r != QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (fill_r != '0);
  assign cmd_data  = q_mem[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + QCNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

/* rtl/core/ssm_back.sv */
// ----------------------------------------------------------------------------
// ssm_back
// Holds both lists, the counts and the overflow flag, walks the two lists
// with one comparison per cycle unless a stalled result channel holds it, and drives the registered result word.
// ----------------------------------------------------------------------------
module ssm_back #(
  parameter int unsigned LIST_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_valid,
  output logic                            cmd_ready,
  input  ssm_pkg::load_cmd_t              cmd_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ssm_pkg::SET_OP_W-1:0]    cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ssm_pkg::out_item_t              out_data
);
  import ssm_pkg::*;

  localparam int unsigned IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);

  logic [ELEM_W-1:0]   mem_a [LIST_DEPTH];
  logic [ELEM_W-1:0]   mem_b [LIST_DEPTH];
  logic [ELEM_W-1:0]   rd_a_r, rd_b_r;

  back_state_t         state_r, state_nxt;
  logic [SET_OP_W-1:0] op_r;
  logic [CNT_W-1:0]    cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CNT_W-1:0]    i_r, i_nxt, j_r, j_nxt;
  logic                ovf_r, ovf_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [ELEM_W-1:0]   pend_val_r, pend_val_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic                pop, we_a, we_b;
  logic                a_ok, b_ok, lt, gt;
  logic                emit, fin, ans, inc_i, inc_j;
  logic [ELEM_W-1:0]   emit_val;
  logic                push_need, slot_free, step_go;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BS_IDLE: begin
        if (cmd_valid && cmd_data.run) begin
          state_nxt = BS_PRIME;
        end
      end
      BS_PRIME: state_nxt = BS_MERGE;
      BS_MERGE: begin
        if (step_go && fin) begin
          state_nxt = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs of the state machine
  // --------------------------------------------------------------------------
  always_comb begin
    cmd_ready = 1'b0;
    case (state_r)
      BS_IDLE:  cmd_ready = 1'b1;
      BS_PRIME: cmd_ready = 1'b0;
      BS_MERGE: cmd_ready = 1'b0;
      default:  cmd_ready = 1'b0;
    endcase
  end

  assign pop  = cmd_valid && cmd_ready;
  assign we_a = pop && cmd_data.store_a && (cnt_a_r < CNT_W'(LIST_DEPTH));
  assign we_b = pop && cmd_data.store_b && (cnt_b_r < CNT_W'(LIST_DEPTH));

  // --------------------------------------------------------------------------
  // One step of the two-pointer walk. rd_a_r and rd_b_r hold A[i] and B[j].
  // --------------------------------------------------------------------------
  always_comb begin
    a_ok     = (i_r < cnt_a_r);
    b_ok     = (j_r < cnt_b_r);
    lt       = (rd_a_r < rd_b_r);
    gt       = (rd_a_r > rd_b_r);
    emit     = 1'b0;
    emit_val = rd_a_r;
    fin      = 1'b0;
    ans      = 1'b0;
    inc_i    = 1'b0;
    inc_j    = 1'b0;
    case (op_r)
      OP_INTERSECT, OP_UNION, OP_DIFF: begin
        if (a_ok && b_ok) begin
          if (lt) begin
            emit  = (op_r != OP_INTERSECT);
            inc_i = 1'b1;
          end else if (gt) begin
            emit     = (op_r == OP_UNION);
            emit_val = rd_b_r;
            inc_j    = 1'b1;
          end else begin
            emit  = (op_r != OP_DIFF);
            inc_i = 1'b1;
            inc_j = 1'b1;
          end
        end else if (a_ok && (op_r != OP_INTERSECT)) begin
          emit  = 1'b1;
          inc_i = 1'b1;
        end else if (b_ok && (op_r == OP_UNION)) begin
          emit     = 1'b1;
          emit_val = rd_b_r;
          inc_j    = 1'b1;
        end else begin
          fin = 1'b1;
        end
      end
      OP_HAS_COMMON: begin
        if (a_ok && b_ok) begin
          if (lt) begin
            inc_i = 1'b1;
          end else if (gt) begin
            inc_j = 1'b1;
          end else begin
            fin = 1'b1;
            ans = 1'b1;
          end
        end else begin
          fin = 1'b1;
        end
      end
      OP_SUBSET, OP_HAS_DIFF: begin
        if (a_ok && b_ok) begin
          if (lt) begin
            fin = 1'b1;
            ans = (op_r == OP_HAS_DIFF);
          end else begin
            inc_i = !gt;
            inc_j = 1'b1;
          end
        end else begin
          fin = 1'b1;
          ans = (op_r == OP_SUBSET) ? (i_r == cnt_a_r) : (i_r != cnt_a_r);
        end
      end
      default: fin = 1'b1;
    endcase
  end

  // A found element waits in the pending register until a later step that emits or
  // finishes shows whether it is the final one of the run.
  assign push_need = fin || (emit && pend_v_r);
  assign slot_free = !out_valid_r || out_ready;
  assign step_go   = (state_r == BS_MERGE) && (!push_need || slot_free);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (step_go && push_need) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.overflow        = ovf_r;
      out_data_nxt.last            = fin;
      if (pend_v_r) begin
        out_data_nxt.result_value    = pend_val_r;
        out_data_nxt.carries_element = 1'b1;
        out_data_nxt.answer          = 1'b0;
      end else begin
        out_data_nxt.result_value    = '0;
        out_data_nxt.carries_element = 1'b0;
        out_data_nxt.answer          = ans;
      end
    end
  end

  always_comb begin
    pend_v_nxt   = pend_v_r;
    pend_val_nxt = pend_val_r;
    if (step_go) begin
      if (emit) begin
        pend_v_nxt   = 1'b1;
        pend_val_nxt = emit_val;
      end else if (fin) begin
        pend_v_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    if (state_r == BS_IDLE) begin
      i_nxt = '0;
      j_nxt = '0;
    end else begin
      i_nxt = (step_go && inc_i) ? i_r + CNT_W'(1) : i_r;
      j_nxt = (step_go && inc_j) ? j_r + CNT_W'(1) : j_r;
    end
  end

  always_comb begin
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    ovf_nxt   = ovf_r;
    if (we_a) begin
      cnt_a_nxt = cnt_a_r + CNT_W'(1);
    end
    if (we_b) begin
      cnt_b_nxt = cnt_b_r + CNT_W'(1);
    end
    if (pop && ((cmd_data.store_a && !we_a) || (cmd_data.store_b && !we_b))) begin
      ovf_nxt = 1'b1;
    end
    if (step_go && fin) begin
      cnt_a_nxt = '0;
      cnt_b_nxt = '0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      op_r        <= OP_INTERSECT;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        op_r <= cfg_data;
      end
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      ovf_r       <= ovf_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_val_r <= pend_val_nxt;
    out_data_r <= out_data_nxt;
  end

  // List memories: one write port and one registered read port each.
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[cnt_a_r[IDX_W-1:0]] <= cmd_data.element;
    end
    rd_a_r <= mem_a[i_nxt[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[cnt_b_r[IDX_W-1:0]] <= cmd_data.element;
    end
    rd_b_r <= mem_b[j_nxt[IDX_W-1:0]];
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= CNT_W'(LIST_DEPTH)) && (cnt_b_r <= CNT_W'(LIST_DEPTH)))
    else $error("list count beyond capacity");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_MERGE) |-> ((i_r <= cnt_a_r) && (j_r <= cnt_b_r)))
    else $error("walk pointer past list end");

  a_pend_merge: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (state_r == BS_MERGE))
    else $error("pending element outside a run");

  a_clear_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    (step_go && fin) |=> ((cnt_a_r == '0) && (cnt_b_r == '0) && !ovf_r && out_valid_r
                          && out_data_r.last && (state_r == BS_IDLE)))
    else $error("run did not finish cleanly");

endmodule

/* rtl/core/sorted_set_merge_operations.sv */
// ----------------------------------------------------------------------------
// sorted_set_merge_operations
// Loads two ascending lists and merges them under the configured set
// operation or test, giving result words in merge order with a last mark.
// ----------------------------------------------------------------------------
//  channel  ports                            word
//  in       in_valid / in_ready / in_data    which_list, element, has_element, run
//  out      out_valid / out_ready / out_data result_value, carries_element,
//                                            answer, overflow, last
//  cfg      cfg_valid / cfg_ready / cfg_data set_operation (always ready)
//
//  The back end accepts a load word whenever it is idle; the front queue takes
//  a word every cycle while it has room. A run word first passes the prime
//  state that primes the list reads, then walks at most count_a + count_b + 1
//  steps, each step one compare of the two list heads read from the list memories.
//  Reset is synchronous, active low, and empties both lists and the queue.
//  A stalled result channel holds the walk only when a word must be sent.
// ----------------------------------------------------------------------------
module sorted_set_merge_operations #(
  parameter int unsigned LIST_DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ssm_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ssm_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ssm_pkg::SET_OP_W-1:0] cfg_data
);
  import ssm_pkg::*;

  logic      cmd_valid;
  logic      cmd_ready;
  load_cmd_t cmd_data;

  ssm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data)
  );

  ssm_back #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* sim/sorted_set_merge_operations_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_merge_operations_tb
// Self-checking bench for the sorted set merge unit. A short table of directed
// words is followed by random load sequences under every operation setting.
// Each accepted input word is fed to a local model of the two lists, and
// every result word is compared field by field with the predicted one.
// ----------------------------------------------------------------------------
module sorted_set_merge_operations_tb;
  import ssm_pkg::*;

  localparam int LIST_DEPTH    = 32;
  localparam int RANDOM_ITEMS  = 270;
  localparam int SETTLE_CYCLES = 10;
  localparam int LONG_HOLD     = 200;
  localparam int DIRECTED_ROWS = 25;

  localparam logic LIST_B = 1'b1;

  // Codes the register can hold but that name no operation.
  localparam logic [SET_OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [SET_OP_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam out_item_t NO_WORD    = '0;
  localparam out_item_t EMPTY_SET  = '{result_value: '0, carries_element: 1'b0,
                                       answer: 1'b0, overflow: 1'b0, last: 1'b1};
  localparam out_item_t ANSWER_NO  = '{result_value: '0, carries_element: 1'b0,
                                       answer: 1'b0, overflow: 1'b0, last: 1'b1};
  localparam out_item_t ANSWER_YES = '{result_value: '0, carries_element: 1'b0,
                                       answer: 1'b1, overflow: 1'b0, last: 1'b1};

  typedef struct packed {
    logic                new_op;
    logic [SET_OP_W-1:0] op;
    in_item_t            word;
    logic                typed;
    out_item_t           outcome;
  } plan_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [SET_OP_W-1:0] cfg_data;

  // Local copy of the block's lists and register.
  logic [ELEM_W-1:0]   set_a [LIST_DEPTH];
  logic [ELEM_W-1:0]   set_b [LIST_DEPTH];
  int                  fill_a;
  int                  fill_b;
  logic                dropped;
  logic [SET_OP_W-1:0] op_setting;

  out_item_t fresh_words [$];
  out_item_t pending_results [$];
  plan_row_t directed_plan [DIRECTED_ROWS];

  int mismatches;
  int fed_items;
  int results_seen;
  int overflow_runs;
  int settings_used;
  bit quiet;
  bit long_hold_req;

  sorted_set_merge_operations #(
    .LIST_DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic in_item_t load_word(logic which, logic [ELEM_W-1:0] elem,
                                         logic has, logic run);
    in_item_t w;
    w.which_list  = which;
    w.element     = elem;
    w.has_element = has;
    w.run         = run;
    return w;
  endfunction

  function automatic void emit_word(logic [ELEM_W-1:0] value, logic carries, logic ans);
    out_item_t r;
    r.result_value    = value;
    r.carries_element = carries;
    r.answer          = ans;
    r.overflow        = dropped;
    r.last            = 1'b0;
    fresh_words.push_back(r);
  endfunction

  // Stores the word's element, and on a run walks both lists with two
  // pointers under the current operation, leaving the result words in
  // fresh_words.
  function automatic void merge_outcome(in_item_t w);
    logic [ELEM_W-1:0] x;
    logic [ELEM_W-1:0] y;
    out_item_t         tail;
    int                i;
    int                j;
    logic              ans;
    bit                done;
    fresh_words.delete();
    if (w.has_element) begin
      if (w.which_list == LIST_A) begin
        if (fill_a < LIST_DEPTH) begin
          set_a[fill_a] = w.element;
          fill_a++;
        end else begin
          dropped = 1'b1;
        end
      end else begin
        if (fill_b < LIST_DEPTH) begin
          set_b[fill_b] = w.element;
          fill_b++;
        end else begin
          dropped = 1'b1;
        end
      end
    end
    if (!w.run) return;

    i    = 0;
    j    = 0;
    ans  = 1'b0;
    done = 1'b0;
    if (op_setting == OP_INTERSECT || op_setting == OP_UNION || op_setting == OP_DIFF) begin
      while (i < fill_a && j < fill_b) begin
        x = set_a[i];
        y = set_b[j];
        if (x < y) begin
          if (op_setting != OP_INTERSECT) emit_word(x, 1'b1, 1'b0);
          i++;
        end else if (x > y) begin
          if (op_setting == OP_UNION) emit_word(y, 1'b1, 1'b0);
          j++;
        end else begin
          if (op_setting != OP_DIFF) emit_word(x, 1'b1, 1'b0);
          i++;
          j++;
        end
      end
      if (op_setting != OP_INTERSECT) begin
        while (i < fill_a) begin
          emit_word(set_a[i], 1'b1, 1'b0);
          i++;
        end
      end
      if (op_setting == OP_UNION) begin
        while (j < fill_b) begin
          emit_word(set_b[j], 1'b1, 1'b0);
          j++;
        end
      end
      if (fresh_words.size() == 0) emit_word('0, 1'b0, 1'b0);
    end else if (op_setting == OP_HAS_COMMON || op_setting == OP_SUBSET ||
                 op_setting == OP_HAS_DIFF) begin
      while (!done && i < fill_a && j < fill_b) begin
        x = set_a[i];
        y = set_b[j];
        if (op_setting == OP_HAS_COMMON) begin
          if (x < y) i++;
          else if (x > y) j++;
          else begin
            ans  = 1'b1;
            done = 1'b1;
          end
        end else if (x < y) begin
          // A head below the B head: A holds an element that B lacks.
          ans  = (op_setting == OP_HAS_DIFF);
          done = 1'b1;
        end else begin
          if (x == y) i++;
          j++;
        end
      end
      if (!done) begin
        if (op_setting == OP_HAS_COMMON) ans = 1'b0;
        else if (op_setting == OP_SUBSET) ans = (i == fill_a);
        else ans = (i != fill_a);
      end
      emit_word('0, 1'b0, ans);
    end else begin
      emit_word('0, 1'b0, 1'b0);
    end
    tail      = fresh_words.pop_back();
    tail.last = 1'b1;
    fresh_words.push_back(tail);
    if (dropped) overflow_runs++;
    fill_a  = 0;
    fill_b  = 0;
    dropped = 1'b0;
  endfunction

  task automatic send_word(in_item_t w, logic typed, out_item_t typed_word);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    merge_outcome(w);
    if (typed) pending_results.push_back(typed_word);
    else foreach (fresh_words[k]) pending_results.push_back(fresh_words[k]);
    if (w.has_element || w.run) fed_items++;
    @(negedge clk);
  endtask

  // Holds the sender until every expected word has come back, then lets the
  // back end finish any load words still in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_setting(logic [SET_OP_W-1:0] op);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= op;
    do @(posedge clk); while (!cfg_ready);
    op_setting = op;
    settings_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Ascending values shared out between the lists, so that equal heads occur.
  // forced_list below zero spreads the values over A, B or both.
  task automatic feed_sets(int steps, int forced_list, int scramble_pct);
    logic [ELEM_W-1:0] v;
    int                pick;
    int                roll;
    in_item_t          w;
    roll = $urandom_range(0, 3);
    if (roll == 0) v = '0;
    else if (roll == 1) v = 32'hFFFF_FF00;
    else v = $urandom_range(0, 32'hFFFF_FF00);
    for (int s = 0; s < steps; s++) begin
      v += $urandom_range(1, 3);
      pick = (forced_list >= 0) ? forced_list : $urandom_range(0, 2);
      for (int l = 0; l < 2; l++) begin
        if (pick == l || pick == 2) begin
          w = load_word((l == 1) ? LIST_B : LIST_A,
                        ($urandom_range(0, 99) < scramble_pct) ? $urandom : v, 1'b1, 1'b0);
          send_word(w, 1'b0, NO_WORD);
        end
        if ($urandom_range(0, 15) == 0) begin
          w = load_word($urandom_range(0, 1), $urandom, 1'b0, 1'b0);
          send_word(w, 1'b0, NO_WORD);
        end
      end
    end
    w = load_word($urandom_range(0, 1), v + 1, $urandom_range(0, 1), 1'b1);
    send_word(w, 1'b0, NO_WORD);
  endtask

  task automatic feed_noise(int count);
    in_item_t w;
    repeat (count) begin
      w = load_word($urandom_range(0, 1), $urandom, $urandom_range(0, 1),
                    $urandom_range(0, 3) == 0);
      send_word(w, 1'b0, NO_WORD);
    end
  endtask

  function automatic void check_field(string field, logic [ELEM_W-1:0] want,
                                      logic [ELEM_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %p", out_data);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_value", want.result_value, out_data.result_value);
        check_field("carries_element", want.carries_element, out_data.carries_element);
        check_field("answer", want.answer, out_data.answer);
        check_field("overflow", want.overflow, out_data.overflow);
        check_field("last", want.last, out_data.last);
        results_seen++;
      end
    end
  end

  // Result side: short random stalls, and one long hold that backs the block
  // up into its input.
  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("sorted_set_merge_operations_tb NOT OK");
    $finish;
  end

  initial begin
    int                  phase;
    int                  mode;
    int                  stop_at;
    logic [SET_OP_W-1:0] next_op;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    fill_a        = 0;
    fill_b        = 0;
    dropped       = 1'b0;
    op_setting    = OP_INTERSECT;
    mismatches    = 0;
    fed_items     = 0;
    results_seen  = 0;
    overflow_runs = 0;
    settings_used = 0;
    quiet         = 1'b0;
    long_hold_req = 1'b0;

    directed_plan = '{
      // Register still at its reset value: an empty intersection.
      '{1'b0, OP_INTERSECT, load_word(LIST_A, 32'd0, 1'b0, 1'b1), 1'b1, EMPTY_SET},
      '{1'b0, OP_INTERSECT, load_word(LIST_A, 32'd0, 1'b1, 1'b0), 1'b0, NO_WORD},
      '{1'b0, OP_INTERSECT, load_word(LIST_A, 32'd5, 1'b1, 1'b0), 1'b0, NO_WORD},
      '{1'b0, OP_INTERSECT, load_word(LIST_A, 32'hFFFF_FFFF, 1'b1, 1'b0), 1'b0, NO_WORD},
      '{1'b0, OP_INTERSECT, load_word(LIST_B, 32'd5, 1'b1, 1'b0), 1'b0, NO_WORD},
      '{1'b0, OP_INTERSECT, load_word(LIST_B, 32'hFFFF_FFFF, 1'b1, 1'b1), 1'b0, NO_WORD},
      '{1'b1, OP_UNION, load_word(LIST_A, 32'd1, 1'b1, 1'b0), 1'b0, NO_WORD},
      '{1'b0, OP_UNION, load_word(LIST_B, 32'd2, 1'b1, 1'b0), 1'b0, NO_WORD},
      '{1'b0, OP_UNION, load_word(LIST_A, 32'hDEAD_BEEF, 1'b0, 1'b0), 1'b0, NO_WORD},
      '{1'b0, OP_UNION, load_word(LIST_B, 32'd3, 1'b1, 1'b1), 1'b0, NO_WORD},
      '{1'b1, OP_DIFF, load_word(LIST_A, 32'd10, 1'b1, 1'b0), 1'b0, NO_WORD},
      '{1'b0, OP_DIFF, load_word(LIST_A, 32'd20, 1'b1, 1'b0), 1'b0, NO_WORD},
      '{1'b0, OP_DIFF, load_word(LIST_B, 32'd10, 1'b1, 1'b1), 1'b0, NO_WORD},
      '{1'b0, OP_DIFF, load_word(LIST_A, 32'd7, 1'b1, 1'b0), 1'b0, NO_WORD},
      '{1'b0, OP_DIFF, load_word(LIST_B, 32'd7, 1'b1, 1'b1), 1'b1, EMPTY_SET},
      '{1'b1, OP_HAS_COMMON, load_word(LIST_A, 32'd4, 1'b1, 1'b0), 1'b0, NO_WORD},
      '{1'b0, OP_HAS_COMMON, load_word(LIST_B, 32'd4, 1'b1, 1'b1), 1'b1, ANSWER_YES},
      '{1'b1, OP_SUBSET, load_word(LIST_A, 32'd3, 1'b1, 1'b0), 1'b0, NO_WORD},
      '{1'b0, OP_SUBSET, load_word(LIST_B, 32'd1, 1'b1, 1'b1), 1'b0, NO_WORD},
      '{1'b1, OP_HAS_DIFF, load_word(LIST_B, 32'd0, 1'b0, 1'b1), 1'b1, ANSWER_NO},
      '{1'b1, OP_UNUSED_LO, load_word(LIST_A, 32'd9, 1'b1, 1'b1), 1'b1, ANSWER_NO},
      '{1'b1, OP_UNUSED_HI, load_word(LIST_B, 32'd9, 1'b1, 1'b1), 1'b1, ANSWER_NO},
      // List A out of order: the walk runs unchanged.
      '{1'b1, OP_UNION, load_word(LIST_A, 32'd8, 1'b1, 1'b0), 1'b0, NO_WORD},
      '{1'b0, OP_UNION, load_word(LIST_A, 32'd2, 1'b1, 1'b0), 1'b0, NO_WORD},
      '{1'b0, OP_UNION, load_word(LIST_B, 32'd5, 1'b1, 1'b1), 1'b0, NO_WORD}
    };

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[r]) begin
      if (directed_plan[r].new_op) write_setting(directed_plan[r].op);
      send_word(directed_plan[r].word, directed_plan[r].typed, directed_plan[r].outcome);
    end

    phase   = 0;
    stop_at = fed_items + RANDOM_ITEMS;
    while (fed_items < stop_at) begin
      // Each setting change also drains the block with the sender paused.
      next_op = (phase < 6) ? 3'(phase) : 3'($urandom_range(OP_INTERSECT, OP_UNUSED_HI));
      write_setting(next_op);
      if (phase == 1) long_hold_req = 1'b1;
      repeat ($urandom_range(2, 5)) begin
        quiet = (fed_items >= stop_at - 40);
        mode  = $urandom_range(0, 19);
        if (mode == 0) feed_sets($urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 3),
                                 $urandom_range(0, 1), 0);
        else if (mode == 1) feed_sets($urandom_range(40, 48), -1, 0);
        else if (mode <= 3) feed_noise($urandom_range(1, 6));
        else feed_sets($urandom_range(0, 10), -1, ($urandom_range(0, 6) == 0) ? 30 : 0);
      end
      phase++;
    end

    settle();
    $display("Fed %0d input words and checked %0d result words over %0d register writes.",
             fed_items, results_seen, settings_used);
    $display("%0d runs carried the overflow mark; %0d mismatches.", overflow_runs, mismatches);
    if (mismatches == 0) begin
      $display("sorted_set_merge_operations_tb OK");
    end else begin
      $display("sorted_set_merge_operations_tb NOT OK");
    end
    $finish;
  end

endmodule
